// File: rtl/core/pvl_pkg.sv
// shared constants, codes and types for the pin verifier with lockout
package pvl_pkg;

    localparam int MAX_PIN_DIGITS = 8;
    localparam int CNT_W          = $clog2(MAX_PIN_DIGITS + 1);
    localparam int IDX_W          = $clog2(MAX_PIN_DIGITS);
    localparam int CMP_W          = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [31:0] FNV_BASIS  = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;

    localparam logic [31:0] RST_STORED_HASH   = 32'h6222_E842;
    localparam logic [3:0]  RST_MAX_ATTEMPTS  = 4'd3;
    localparam logic [15:0] RST_LOCKOUT_TICKS = 16'd30;
    localparam logic [3:0]  RST_MIN_LEN       = 4'd4;

    localparam logic [3:0]  MAX_DIGIT_VAL = 4'd9;
    localparam logic [3:0]  FAIL_TOP      = 4'd15;

    typedef enum logic [1:0] {
        CMD_DIGIT = 2'd0,
        CMD_BKSP  = 2'd1,
        CMD_ENTER = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_TAKEN    = 4'd0,
        ST_DELETED  = 4'd1,
        ST_IGNORED  = 4'd2,
        ST_SHORT    = 4'd3,
        ST_GRANTED  = 4'd4,
        ST_WRONG    = 4'd5,
        ST_LOCKNOW  = 4'd6,
        ST_COUNTING = 4'd7,
        ST_UNLOCKED = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CFG_STORED_HASH   = 2'd0,
        CFG_MAX_ATTEMPTS  = 2'd1,
        CFG_LOCKOUT_TICKS = 2'd2,
        CFG_MIN_LEN       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic step;
    } t_fnv_ctl;

endpackage

// File: rtl/core/pvl_fnv_unit.sv
// shared fnv-1a round unit: one xor and multiply per cycle on the running hash
module pvl_fnv_unit (
    input  logic               i_clk,
    input  pvl_pkg::t_fnv_ctl  i_ctl,
    input  logic [3:0]         i_digit,
    output logic [31:0]        o_hash
);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] mix;

    assign mix = r_hash ^ (32'(pvl_pkg::ASCII_ZERO) + 32'(i_digit));

    always_comb begin
        n_hash = r_hash;
        if (i_ctl.load) begin
            n_hash = pvl_pkg::FNV_BASIS;
        end else if (i_ctl.step) begin
            n_hash = mix * pvl_pkg::FNV_PRIME;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_hash = r_hash;

endmodule

// File: rtl/core/pin_verifier_with_lockout_unit.sv
// top level: keypad sequencer, digit store, lockout state and result register
// Each keypad request or tick is answered from an output register. Digit,
// backspace, tick, empty, short and locked requests go from idle straight to the
// update state; an enter that is checked first passes the hash state, where the
// single fnv round unit hashes one digit a cycle for n entered digits (at most eight).
// The input stall is high from acceptance until the result is in the output
// register, which may still hold one untaken result while the next request enters.
// Configuration writes are always ready and take effect at once.
module pin_verifier_with_lockout_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_digit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [3:0]  o_entry_length,
    output logic [3:0]  o_failed_attempts,
    output logic        o_locked,
    output logic [15:0] o_seconds_left,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_HASH   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_stored_hash;
    logic [3:0]  r_max_attempts;
    logic [15:0] r_lockout_ticks;
    logic [3:0]  r_min_len;

    // keypad state
    logic [3:0]                r_digits [pvl_pkg::MAX_PIN_DIGITS];
    logic [pvl_pkg::CNT_W-1:0] r_count, n_count;
    logic [3:0]                r_fail, n_fail;
    logic                      r_lock, n_lock;
    logic [15:0]               r_cd, n_cd;

    // request in work
    pvl_pkg::t_cmd             r_cmd;
    logic [3:0]                r_dig;
    logic [pvl_pkg::IDX_W-1:0] r_idx;
    logic [pvl_pkg::CNT_W-1:0] r_left;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_status;
    logic [3:0]  r_entry_length;
    logic [3:0]  r_failed;
    logic        r_locked;
    logic [15:0] r_secs;

    pvl_pkg::t_status  n_status;
    pvl_pkg::t_fnv_ctl fnv_ctl;
    logic [31:0]       hash;
    logic              in_accept;
    logic              out_free;
    logic              commit;
    logic              wr_digit;
    logic              too_short;
    logic              need_hash;
    logic [3:0]        fail_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign commit      = (r_state == S_UPDATE) && out_free;

    assign too_short = pvl_pkg::CMP_W'(r_count) < pvl_pkg::CMP_W'(r_min_len);
    assign need_hash = (pvl_pkg::t_cmd'(i_cmd) == pvl_pkg::CMD_ENTER) && !r_lock
                       && !too_short && (r_count != '0);
    assign fail_inc  = (r_fail != pvl_pkg::FAIL_TOP) ? (r_fail + 4'd1) : r_fail;

    assign fnv_ctl.load = in_accept;
    assign fnv_ctl.step = (r_state == S_HASH);

    pvl_fnv_unit u_fnv (
        .i_clk   (i_clk),
        .i_ctl   (fnv_ctl),
        .i_digit (r_digits[r_idx]),
        .o_hash  (hash)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = need_hash ? S_HASH : S_UPDATE;
                end
            end
            S_HASH: begin
                if (r_left == pvl_pkg::CNT_W'(1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // request decode, applied when the result is loaded
    always_comb begin
        n_count  = r_count;
        n_fail   = r_fail;
        n_lock   = r_lock;
        n_cd     = r_cd;
        n_status = pvl_pkg::ST_IGNORED;
        wr_digit = 1'b0;
        case (r_cmd)
            pvl_pkg::CMD_TICK: begin
                if (r_lock) begin
                    if (r_cd <= 16'd1) begin
                        n_lock   = 1'b0;
                        n_cd     = '0;
                        n_fail   = '0;
                        n_status = pvl_pkg::ST_UNLOCKED;
                    end else begin
                        n_cd     = r_cd - 16'd1;
                        n_status = pvl_pkg::ST_COUNTING;
                    end
                end
            end
            pvl_pkg::CMD_DIGIT: begin
                if (!r_lock && (r_dig <= pvl_pkg::MAX_DIGIT_VAL)
                    && (r_count < pvl_pkg::CNT_W'(pvl_pkg::MAX_PIN_DIGITS))) begin
                    wr_digit = 1'b1;
                    n_count  = r_count + pvl_pkg::CNT_W'(1);
                    n_status = pvl_pkg::ST_TAKEN;
                end
            end
            pvl_pkg::CMD_BKSP: begin
                if (!r_lock && (r_count != '0)) begin
                    n_count  = r_count - pvl_pkg::CNT_W'(1);
                    n_status = pvl_pkg::ST_DELETED;
                end
            end
            pvl_pkg::CMD_ENTER: begin
                if (!r_lock) begin
                    if (too_short) begin
                        n_status = pvl_pkg::ST_SHORT;
                    end else begin
                        n_count = '0;
                        if (hash == r_stored_hash) begin
                            n_fail   = '0;
                            n_status = pvl_pkg::ST_GRANTED;
                        end else begin
                            n_fail = fail_inc;
                            if (fail_inc >= r_max_attempts) begin
                                n_lock   = 1'b1;
                                n_cd     = r_lockout_ticks;
                                n_status = pvl_pkg::ST_LOCKNOW;
                            end else begin
                                n_status = pvl_pkg::ST_WRONG;
                            end
                        end
                    end
                end
            end
            default: n_status = pvl_pkg::ST_IGNORED;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_fail          <= '0;
            r_lock          <= 1'b0;
            r_cd            <= '0;
            r_out_valid     <= 1'b0;
            r_stored_hash   <= pvl_pkg::RST_STORED_HASH;
            r_max_attempts  <= pvl_pkg::RST_MAX_ATTEMPTS;
            r_lockout_ticks <= pvl_pkg::RST_LOCKOUT_TICKS;
            r_min_len       <= pvl_pkg::RST_MIN_LEN;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_fail      <= n_fail;
                r_lock      <= n_lock;
                r_cd        <= n_cd;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (pvl_pkg::t_cfg_idx'(i_cfg_index))
                    pvl_pkg::CFG_STORED_HASH:   r_stored_hash   <= i_cfg_data;
                    pvl_pkg::CFG_MAX_ATTEMPTS:  r_max_attempts  <= i_cfg_data[3:0];
                    pvl_pkg::CFG_LOCKOUT_TICKS: r_lockout_ticks <= i_cfg_data[15:0];
                    pvl_pkg::CFG_MIN_LEN:       r_min_len       <= i_cfg_data[3:0];
                    default: r_min_len <= r_min_len;
                endcase
            end
        end
    end

    // payload: request, round counters, digit store, result fields
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= pvl_pkg::t_cmd'(i_cmd);
            r_dig  <= i_digit;
            r_idx  <= '0;
            r_left <= r_count;
        end else if (r_state == S_HASH) begin
            r_idx  <= r_idx + pvl_pkg::IDX_W'(1);
            r_left <= r_left - pvl_pkg::CNT_W'(1);
        end
        if (commit && wr_digit) begin
            r_digits[r_count[pvl_pkg::IDX_W-1:0]] <= r_dig;
        end
        if (commit) begin
            r_status       <= n_status;
            r_entry_length <= 4'(n_count);
            r_failed       <= n_fail;
            r_locked       <= n_lock;
            r_secs         <= n_lock ? n_cd : 16'd0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_entry_length    = r_entry_length;
    assign o_failed_attempts = r_failed;
    assign o_locked          = r_locked;
    assign o_seconds_left    = r_secs;

endmodule

// File: bench/pin_verifier_with_lockout_unit_test.sv
// self-checking testbench for the pin verifier with lockout: directed keys, then random sessions
module pin_verifier_with_lockout_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 95;

    typedef struct packed {
        pvl_pkg::t_status status;
        logic [3:0]       entry_len;
        logic [3:0]       fails;
        logic             locked;
        logic [15:0]      secs;
    } t_pin_result;

    typedef struct packed {
        pvl_pkg::t_cmd cmd;
        logic [3:0]    digit;
        logic          typed;
        t_pin_result   want;
    } t_key_row;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              key_valid = 1'b0;
    logic              key_stall;
    pvl_pkg::t_cmd     key_cmd   = pvl_pkg::CMD_DIGIT;
    logic [3:0]        key_digit = 4'd0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [3:0]        res_status;
    logic [3:0]        res_entry_len;
    logic [3:0]        res_fails;
    logic              res_locked;
    logic [15:0]       res_secs;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    pvl_pkg::t_cfg_idx cfg_index = pvl_pkg::CFG_STORED_HASH;
    logic [31:0]       cfg_data  = 32'd0;

    // predictor copy of the registers and the lockout state
    logic [31:0] cf_hash      = pvl_pkg::RST_STORED_HASH;
    logic [3:0]  cf_max       = pvl_pkg::RST_MAX_ATTEMPTS;
    logic [15:0] cf_ticks     = pvl_pkg::RST_LOCKOUT_TICKS;
    logic [3:0]  cf_min       = pvl_pkg::RST_MIN_LEN;
    logic [31:0] pv_entry     = '0;
    int          pv_count     = 0;
    logic [3:0]  pv_fails     = '0;
    logic        pv_locked    = 1'b0;
    logic [15:0] pv_countdown = '0;

    t_pin_result pending_results[$];
    logic [31:0] secret_digits = '0;
    int          secret_len    = 4;
    int          sender_pct    = 0;
    int          recv_pct      = 0;
    int          sent_items    = 0;
    int          errors        = 0;
    int          quiet_cycles  = 0;
    logic        hold_start    = 1'b0;
    int          hold_left     = HOLD_CYCLES;

    always #2 clk = ~clk;

    pin_verifier_with_lockout_unit i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (key_valid),
        .o_in_stall        (key_stall),
        .i_cmd             (key_cmd),
        .i_digit           (key_digit),
        .o_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .o_status          (res_status),
        .o_entry_length    (res_entry_len),
        .o_failed_attempts (res_fails),
        .o_locked          (res_locked),
        .o_seconds_left    (res_secs),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    function automatic logic [31:0] fnv_pin(logic [31:0] digs, int n);
        logic [31:0] h;
        h = pvl_pkg::FNV_BASIS;
        for (int i = 0; i < n; i++) begin
            h = h ^ ({24'd0, pvl_pkg::ASCII_ZERO} + {28'd0, digs[4*i +: 4]});
            h = h * pvl_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    function automatic t_pin_result next_keypad_result(pvl_pkg::t_cmd c, logic [3:0] d);
        t_pin_result r;
        logic [31:0] h;
        r.status = pvl_pkg::ST_IGNORED;
        if (c == pvl_pkg::CMD_TICK) begin
            if (pv_locked) begin
                if (pv_countdown <= 16'd1) begin
                    pv_locked    = 1'b0;
                    pv_countdown = '0;
                    pv_fails     = '0;
                    r.status     = pvl_pkg::ST_UNLOCKED;
                end else begin
                    pv_countdown = pv_countdown - 16'd1;
                    r.status     = pvl_pkg::ST_COUNTING;
                end
            end
        end else if (!pv_locked) begin
            case (c)
                pvl_pkg::CMD_DIGIT: begin
                    if (d <= pvl_pkg::MAX_DIGIT_VAL && pv_count < pvl_pkg::MAX_PIN_DIGITS) begin
                        pv_entry[4*pv_count +: 4] = d;
                        pv_count++;
                        r.status = pvl_pkg::ST_TAKEN;
                    end
                end
                pvl_pkg::CMD_BKSP: begin
                    if (pv_count > 0) begin
                        pv_count--;
                        r.status = pvl_pkg::ST_DELETED;
                    end
                end
                default: begin
                    if (pv_count < int'(cf_min)) begin
                        r.status = pvl_pkg::ST_SHORT;
                    end else begin
                        h        = fnv_pin(pv_entry, pv_count);
                        pv_entry = '0;
                        pv_count = 0;
                        if (h == cf_hash) begin
                            pv_fails = '0;
                            r.status = pvl_pkg::ST_GRANTED;
                        end else begin
                            if (pv_fails < pvl_pkg::FAIL_TOP)
                                pv_fails++;
                            if (pv_fails >= cf_max) begin
                                pv_locked    = 1'b1;
                                pv_countdown = cf_ticks;
                                r.status     = pvl_pkg::ST_LOCKNOW;
                            end else begin
                                r.status = pvl_pkg::ST_WRONG;
                            end
                        end
                    end
                end
            endcase
        end
        r.entry_len = 4'(pv_count);
        r.fails     = pv_fails;
        r.locked    = pv_locked;
        r.secs      = pv_locked ? pv_countdown : 16'd0;
        return r;
    endfunction

    function automatic t_key_row key_row(pvl_pkg::t_cmd c, logic [3:0] d, logic typed,
                                         pvl_pkg::t_status s, logic [3:0] len);
        t_key_row k;
        k.cmd       = c;
        k.digit     = d;
        k.typed     = typed;
        k.want      = '0;
        k.want.status    = s;
        k.want.entry_len = len;
        return k;
    endfunction

    function automatic logic [3:0] pick_digit();
        return ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    endfunction

    task automatic send_key(pvl_pkg::t_cmd c, logic [3:0] d, logic typed, t_pin_result want);
        t_pin_result got;
        while ($urandom_range(99) < sender_pct) begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_cmd   <= c;
        key_digit <= d;
        @(posedge clk);
        while (key_stall) @(posedge clk);
        got = next_keypad_result(c, d);
        pending_results.push_back(typed ? want : got);
        sent_items++;
    endtask

    task automatic press(pvl_pkg::t_cmd c, logic [3:0] d);
        send_key(c, d, 1'b0, '0);
    endtask

    task automatic write_reg(pvl_pkg::t_cfg_idx idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            pvl_pkg::CFG_STORED_HASH:   cf_hash  = val;
            pvl_pkg::CFG_MAX_ATTEMPTS:  cf_max   = val[3:0];
            pvl_pkg::CFG_LOCKOUT_TICKS: cf_ticks = val[15:0];
            default:                    cf_min   = val[3:0];
        endcase
    endtask

    // upper data bits carry noise, only the register width counts
    task automatic program_lock(logic [31:0] hash, logic [3:0] max_att, logic [15:0] ticks,
                                logic [3:0] min_l);
        write_reg(pvl_pkg::CFG_STORED_HASH, hash);
        write_reg(pvl_pkg::CFG_MAX_ATTEMPTS, ($urandom() << 4) | {28'd0, max_att});
        write_reg(pvl_pkg::CFG_LOCKOUT_TICKS, ($urandom() << 16) | {16'd0, ticks});
        write_reg(pvl_pkg::CFG_MIN_LEN, ($urandom() << 4) | {28'd0, min_l});
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        key_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_session();
        int n;
        if (pv_locked) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(9) == 0)
                    press(pvl_pkg::t_cmd'($urandom_range(2)), 4'($urandom_range(15)));
                else
                    press(pvl_pkg::CMD_TICK, 4'($urandom_range(15)));
            end
        end else begin
            n = $urandom_range(9);
            if (n < 4) begin
                // clear leftovers, then type the secret with the odd correction
                repeat (pv_count) press(pvl_pkg::CMD_BKSP, 4'($urandom_range(15)));
                for (int i = 0; i < secret_len; i++) begin
                    if ($urandom_range(9) == 0) begin
                        press(pvl_pkg::CMD_DIGIT, pick_digit());
                        press(pvl_pkg::CMD_BKSP, 4'($urandom_range(15)));
                    end
                    press(pvl_pkg::CMD_DIGIT, secret_digits[4*i +: 4]);
                end
                press(pvl_pkg::CMD_ENTER, 4'($urandom_range(15)));
            end else if (n < 7) begin
                repeat ($urandom_range(9)) press(pvl_pkg::CMD_DIGIT, pick_digit());
                press(pvl_pkg::CMD_ENTER, 4'($urandom_range(15)));
            end else begin
                repeat ($urandom_range(1, 4))
                    press(pvl_pkg::t_cmd'($urandom_range(3)), 4'($urandom_range(15)));
            end
        end
    endtask

    // receiver: one long hold-off once requested, random stalls otherwise
    always @(posedge clk) begin
        if (hold_start && hold_left != 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            res_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    always @(posedge clk) begin
        t_pin_result w;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                w = pending_results.pop_front();
                if (res_status != w.status) begin
                    $error("status: expected %0d, got %0d", w.status, res_status);
                    errors++;
                end
                if (res_entry_len != w.entry_len) begin
                    $error("entry_length: expected %0d, got %0d", w.entry_len, res_entry_len);
                    errors++;
                end
                if (res_fails != w.fails) begin
                    $error("failed_attempts: expected %0d, got %0d", w.fails, res_fails);
                    errors++;
                end
                if (res_locked != w.locked) begin
                    $error("locked: expected %0d, got %0d", w.locked, res_locked);
                    errors++;
                end
                if (res_secs != w.secs) begin
                    $error("seconds_left: expected %0d, got %0d", w.secs, res_secs);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((key_valid && !key_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("pin_verifier_with_lockout_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_key_row    script[$];
        logic [3:0]  ph_max;
        logic [3:0]  ph_min;
        logic [15:0] ph_ticks;
        logic        ph_rand_hash;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed keys at the reset settings
        script.push_back(key_row(pvl_pkg::CMD_BKSP,  4'd0,  1'b1, pvl_pkg::ST_IGNORED, 4'd0));
        script.push_back(key_row(pvl_pkg::CMD_TICK,  4'd15, 1'b1, pvl_pkg::ST_IGNORED, 4'd0));
        script.push_back(key_row(pvl_pkg::CMD_ENTER, 4'd0,  1'b1, pvl_pkg::ST_SHORT,   4'd0));
        script.push_back(key_row(pvl_pkg::CMD_DIGIT, 4'd0,  1'b1, pvl_pkg::ST_TAKEN,   4'd1));
        script.push_back(key_row(pvl_pkg::CMD_DIGIT, 4'd15, 1'b1, pvl_pkg::ST_IGNORED, 4'd1));
        script.push_back(key_row(pvl_pkg::CMD_DIGIT, 4'd10, 1'b1, pvl_pkg::ST_IGNORED, 4'd1));
        script.push_back(key_row(pvl_pkg::CMD_BKSP,  4'd7,  1'b1, pvl_pkg::ST_DELETED, 4'd0));
        for (int i = 1; i <= 8; i++)
            script.push_back(key_row(pvl_pkg::CMD_DIGIT, 4'(i), 1'b0, pvl_pkg::ST_TAKEN, 4'd0));
        script.push_back(key_row(pvl_pkg::CMD_DIGIT, 4'd9,  1'b1, pvl_pkg::ST_IGNORED, 4'd8));
        script.push_back(key_row(pvl_pkg::CMD_ENTER, 4'd0,  1'b0, pvl_pkg::ST_WRONG,   4'd0));
        for (int i = 1; i <= 4; i++)
            script.push_back(key_row(pvl_pkg::CMD_DIGIT, 4'(i), 1'b0, pvl_pkg::ST_TAKEN, 4'd0));
        script.push_back(key_row(pvl_pkg::CMD_ENTER, 4'd5,  1'b0, pvl_pkg::ST_GRANTED, 4'd0));
        foreach (script[k])
            send_key(script[k].cmd, script[k].digit, script[k].typed, script[k].want);
        settle();

        for (int p = 1; p <= 6; p++) begin
            ph_rand_hash = 1'b0;
            case (p)
                1: begin
                    secret_len = $urandom_range(1, 8);
                    ph_max = 4'd1; ph_ticks = 16'd1; ph_min = 4'd1;
                    sender_pct = 0;
                    recv_pct   <= 0;
                    hold_start <= 1'b1;
                end
                2: begin
                    // zero lockout ends on the first tick
                    secret_len = 8;
                    ph_max = 4'd15; ph_ticks = 16'd0; ph_min = 4'd8;
                    sender_pct = 85;
                    recv_pct   <= 0;
                end
                3: begin
                    // first failure locks, empty entry is checked
                    secret_len = $urandom_range(1, 8);
                    ph_max = 4'd0; ph_ticks = 16'd3; ph_min = 4'd0;
                    ph_rand_hash = 1'b1;
                    sender_pct = 0;
                    recv_pct   <= 85;
                end
                4: begin
                    // min length above the store size: every enter is short
                    secret_len = $urandom_range(1, 8);
                    ph_max   = 4'($urandom_range(1, 15));
                    ph_ticks = 16'($urandom_range(2, 40));
                    ph_min   = 4'($urandom_range(9, 15));
                    sender_pct = 27;
                    recv_pct   <= 27;
                end
                5: begin
                    secret_len = $urandom_range(4, 8);
                    ph_max   = 4'($urandom_range(2, 5));
                    ph_ticks = 16'($urandom_range(5, 30));
                    ph_min   = 4'd4;
                    sender_pct = 0;
                    recv_pct   <= 0;
                end
                default: begin
                    secret_len = $urandom_range(4, 8);
                    ph_max = 4'd2; ph_ticks = 16'hFFFF; ph_min = 4'($urandom_range(1, 4));
                    sender_pct = 27;
                    recv_pct   <= 27;
                end
            endcase
            secret_digits = '0;
            for (int i = 0; i < secret_len; i++)
                secret_digits[4*i +: 4] = 4'($urandom_range(9));
            program_lock(ph_rand_hash ? $urandom() : fnv_pin(secret_digits, secret_len),
                         ph_max, ph_ticks, ph_min);
            sent_items = 0;
            while (sent_items < PHASE_ITEMS)
                run_session();
            settle();
        end

        if (errors == 0)
            $display("pin_verifier_with_lockout_unit test passed");
        else
            $display("pin_verifier_with_lockout_unit test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pvl_pkg.sv
rtl/core/pvl_fnv_unit.sv
rtl/core/pin_verifier_with_lockout_unit.sv
bench/pin_verifier_with_lockout_unit_test.sv
